// File: rtl/tlbl_pkg.sv
// Shared constants and codes for the tree LCA binary-lifting block.
`default_nettype none
package tlbl_pkg;

    localparam int unsigned NODE_W        = 11;
    localparam int unsigned MAX_NODES_DEF = 1024;
    localparam int unsigned LEVELS_DEF    = 10;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_BUILD = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTBUILT = 2'd3;

    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_ROOT_NODE  = 1'b1;

endpackage
`default_nettype wire

// File: rtl/tree_lca_binary_lifting.sv
// Top level: lowest common ancestor by binary lifting over RAM-held tables.
// Build: clear the node table, then walk depth first from the root, writing one row
// per visited node and skipping other edges; the node-table read port sets the pace.
// One item is in work at a time; a finished result waits in the output register.
// Reset (synchronous, active low) starts a clearing pass over the adjacency heads and
// the node table; no item is accepted until it ends.
`default_nettype none
module tree_lca_binary_lifting
    import tlbl_pkg::*;
#(
    parameter int unsigned MAX_NODES = MAX_NODES_DEF,
    parameter int unsigned LEVELS    = LEVELS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_req_type,
    input  wire logic [NODE_W-1:0] i_node_a,
    input  wire logic [NODE_W-1:0] i_node_b,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [NODE_W-1:0]      o_result_node,
    output logic [1:0]             o_status,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_index,
    input  wire logic [NODE_W-1:0] i_cfg_data
);

    localparam int unsigned NW       = NODE_W;
    localparam int unsigned EDGE_CAP = 2 * (MAX_NODES - 1);
    // node-indexed tables hold ids 0..MAX_NODES
    localparam int unsigned AW   = $clog2(MAX_NODES + 1);
    localparam int unsigned EIW  = (EDGE_CAP > 1) ? $clog2(EDGE_CAP) : 1;
    localparam int unsigned HW   = $clog2(EDGE_CAP + 1);
    localparam int unsigned SW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int unsigned DW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int unsigned LCW  = $clog2(LEVELS + 1);
    localparam int unsigned RWD  = DW + LEVELS * NW;
    localparam int unsigned EFFW = (NW > AW) ? NW : AW;

    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_DEC     = 5'd2;
    localparam logic [4:0] S_AE_A    = 5'd3;
    localparam logic [4:0] S_AE_B    = 5'd4;
    localparam logic [4:0] S_B_ROOT  = 5'd5;
    localparam logic [4:0] S_B_TOP   = 5'd6;
    localparam logic [4:0] S_B_POP   = 5'd7;
    localparam logic [4:0] S_B_EDGE  = 5'd8;
    localparam logic [4:0] S_B_CHK   = 5'd9;
    localparam logic [4:0] S_B_VL    = 5'd10;
    localparam logic [4:0] S_B_VWR   = 5'd11;
    localparam logic [4:0] S_B_PUSH  = 5'd12;
    localparam logic [4:0] S_Q_A     = 5'd13;
    localparam logic [4:0] S_Q_B     = 5'd14;
    localparam logic [4:0] S_Q_LIFT  = 5'd15;
    localparam logic [4:0] S_Q_LIFTW = 5'd16;
    localparam logic [4:0] S_Q_EQ    = 5'd17;
    localparam logic [4:0] S_Q_CMP   = 5'd18;
    localparam logic [4:0] S_Q_CU    = 5'd19;
    localparam logic [4:0] S_Q_CV    = 5'd20;
    localparam logic [4:0] S_FIN     = 5'd21;

    // control state
    logic [4:0]     r_state, n_state;
    logic [AW-1:0]  r_clr, n_clr;
    logic           r_clr_adj, n_clr_adj;
    logic [NW-1:0]  r_node_count, n_node_count;
    logic [NW-1:0]  r_root, n_root;
    logic [HW-1:0]  r_fill, n_fill;
    logic           r_built, n_built;
    logic [SW:0]    r_sp, n_sp;
    logic           r_ov, n_ov;
    // payload
    logic [1:0]     r_req, n_req;
    logic [NW-1:0]  r_a, n_a, r_b, n_b;
    logic [NW-1:0]  r_top_node, n_top_node;
    logic [HW-1:0]  r_top_cur, n_top_cur;
    logic [NW-1:0]  r_t, n_t;
    logic [RWD-1:0] r_nrow, n_nrow;
    logic [LCW-1:0] r_lvl, n_lvl;
    logic [NW-1:0]  r_u, n_u, r_v, n_v;
    logic [RWD-1:0] r_urow, n_urow, r_vrow, n_vrow;
    logic [DW-1:0]  r_dif, n_dif;
    logic [NW-1:0]  r_res, n_res, r_ores, n_ores;
    logic [1:0]     r_stat, n_stat, r_ostat, n_ostat;

    // RAM ports
    logic             adj_we;
    logic [AW-1:0]    adj_waddr, adj_raddr;
    logic [HW-1:0]    adj_wdata, adj_rdata;
    logic             edge_we;
    logic [EIW-1:0]   edge_waddr, edge_raddr;
    logic [NW+HW-1:0] edge_wdata, edge_rdata;
    logic             node_we;
    logic [AW-1:0]    node_waddr, node_raddr;
    logic [RWD-1:0]   node_wdata, node_rdata;
    logic             stk_we;
    logic [SW-1:0]    stk_waddr, stk_raddr;
    logic [NW+HW-1:0] stk_wdata, stk_rdata;

    // adjacency list heads: 0 is the empty list, else edge index plus one
    tlbl_ram #(.WIDTH(HW), .DEPTH(MAX_NODES + 1)) u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_raddr(adj_raddr), .o_rdata(adj_rdata)
    );

    // edge store: {target, next link}
    tlbl_ram #(.WIDTH(NW + HW), .DEPTH(EDGE_CAP)) u_edge (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_waddr), .i_wdata(edge_wdata),
        .i_raddr(edge_raddr), .o_rdata(edge_rdata)
    );

    // node table row: {depth, ancestor[LEVELS-1] .. ancestor[0]}
    tlbl_ram #(.WIDTH(RWD), .DEPTH(MAX_NODES + 1)) u_node (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr), .i_wdata(node_wdata),
        .i_raddr(node_raddr), .o_rdata(node_rdata)
    );

    // walk stack below the top frame, which lives in r_top_node / r_top_cur
    tlbl_ram #(.WIDTH(NW + HW), .DEPTH(MAX_NODES)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    // id range checks against the effective node count
    logic [EFFW-1:0] eff_count;
    logic            a_ok, b_ok, root_ok, fill_full;
    logic [NW-1:0]   e_tgt;
    logic [HW-1:0]   nxt_b;
    logic [NW-1:0]   fu, fv;
    logic [DW-1:0]   dsh;
    logic            dbit;

    always_comb begin
        eff_count = (EFFW'(r_node_count) > EFFW'(MAX_NODES)) ? EFFW'(MAX_NODES)
                                                             : EFFW'(r_node_count);
        a_ok      = (r_a != '0) && (EFFW'(r_a) <= eff_count);
        b_ok      = (r_b != '0) && (EFFW'(r_b) <= eff_count);
        root_ok   = (r_root != '0) && (EFFW'(r_root) <= eff_count);
        fill_full = ((HW + 1)'(r_fill) + (HW + 1)'(2)) > (HW + 1)'(EDGE_CAP);
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_ov;
    assign o_result_node = r_ores;
    assign o_status      = r_ostat;

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_clr_adj    = r_clr_adj;
        n_node_count = r_node_count;
        n_root       = r_root;
        n_fill       = r_fill;
        n_built      = r_built;
        n_sp         = r_sp;
        n_ov         = r_ov & i_out_stall;
        n_req        = r_req;
        n_a          = r_a;
        n_b          = r_b;
        n_top_node   = r_top_node;
        n_top_cur    = r_top_cur;
        n_t          = r_t;
        n_nrow       = r_nrow;
        n_lvl        = r_lvl;
        n_u          = r_u;
        n_v          = r_v;
        n_urow       = r_urow;
        n_vrow       = r_vrow;
        n_dif        = r_dif;
        n_res        = r_res;
        n_stat       = r_stat;
        n_ores       = r_ores;
        n_ostat      = r_ostat;

        adj_we     = 1'b0;
        adj_waddr  = '0;
        adj_wdata  = '0;
        adj_raddr  = '0;
        edge_we    = 1'b0;
        edge_waddr = '0;
        edge_wdata = '0;
        edge_raddr = '0;
        node_we    = 1'b0;
        node_waddr = '0;
        node_wdata = '0;
        node_raddr = '0;
        stk_we     = 1'b0;
        stk_waddr  = '0;
        stk_wdata  = '0;
        stk_raddr  = '0;

        e_tgt = edge_rdata[HW +: NW];
        nxt_b = (r_a == r_b) ? HW'(r_fill + HW'(1)) : adj_rdata;
        fu    = r_urow[r_lvl * NW +: NW];
        fv    = r_vrow[r_lvl * NW +: NW];
        dsh   = r_dif >> r_lvl;
        dbit  = dsh[0];

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NODE_COUNT: n_node_count = i_cfg_data;
                CFG_ROOT_NODE:  n_root = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_CLR: begin
                // zero one row a cycle; adjacency heads only after reset
                node_we    = 1'b1;
                node_waddr = r_clr;
                adj_we     = r_clr_adj;
                adj_waddr  = r_clr;
                if (r_clr == AW'(MAX_NODES)) begin
                    if (r_clr_adj) begin
                        n_state = S_IDLE;
                    end else begin
                        adj_raddr = AW'(r_root);
                        n_state   = S_B_ROOT;
                    end
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_req_type;
                    n_a     = i_node_a;
                    n_b     = i_node_b;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_res   = '0;
                n_stat  = ST_OK;
                n_state = S_FIN;
                case (r_req)
                    REQ_ADD: begin
                        if (!a_ok || !b_ok) begin
                            n_stat = ST_RANGE;
                        end else if (fill_full) begin
                            n_stat = ST_FULL;
                        end else begin
                            adj_raddr = AW'(r_a);
                            n_state   = S_AE_A;
                        end
                    end
                    REQ_BUILD: begin
                        if (!root_ok) begin
                            n_stat = ST_RANGE;
                        end else begin
                            n_clr     = '0;
                            n_clr_adj = 1'b0;
                            n_state   = S_CLR;
                        end
                    end
                    REQ_QUERY: begin
                        if (!a_ok || !b_ok) begin
                            n_stat = ST_RANGE;
                        end else if (!r_built) begin
                            n_stat = ST_NOTBUILT;
                        end else begin
                            node_raddr = AW'(r_a);
                            n_state    = S_Q_A;
                        end
                    end
                    default: ;
                endcase
            end
            S_AE_A: begin
                edge_we    = 1'b1;
                edge_waddr = EIW'(r_fill);
                edge_wdata = {r_b, adj_rdata};
                adj_we     = 1'b1;
                adj_waddr  = AW'(r_a);
                adj_wdata  = HW'(r_fill + HW'(1));
                adj_raddr  = AW'(r_b);
                n_state    = S_AE_B;
            end
            S_AE_B: begin
                // self loop: the head of b was just rewritten, forward it
                edge_we    = 1'b1;
                edge_waddr = EIW'(r_fill + HW'(1));
                edge_wdata = {r_a, nxt_b};
                adj_we     = 1'b1;
                adj_waddr  = AW'(r_b);
                adj_wdata  = HW'(r_fill + HW'(2));
                n_fill     = HW'(r_fill + HW'(2));
                n_built    = 1'b0;
                n_state    = S_FIN;
            end
            S_B_ROOT: begin
                // root row is already zero: depth 0, no ancestors
                n_top_node = r_root;
                n_top_cur  = adj_rdata;
                n_sp       = (SW + 1)'(1);
                n_state    = S_B_TOP;
            end
            S_B_TOP: begin
                if (r_sp == '0) begin
                    n_built = 1'b1;
                    n_state = S_FIN;
                end else if (r_top_cur == '0) begin
                    n_sp = r_sp - (SW + 1)'(1);
                    if (r_sp == (SW + 1)'(1)) begin
                        n_state = S_B_TOP;
                    end else begin
                        stk_raddr = SW'(r_sp - (SW + 1)'(2));
                        n_state   = S_B_POP;
                    end
                end else begin
                    edge_raddr = EIW'(r_top_cur - HW'(1));
                    n_state    = S_B_EDGE;
                end
            end
            S_B_POP: begin
                n_top_node = stk_rdata[HW +: NW];
                n_top_cur  = stk_rdata[HW-1:0];
                n_state    = S_B_TOP;
            end
            S_B_EDGE: begin
                n_top_cur = edge_rdata[HW-1:0];
                if ((e_tgt == '0) || (EFFW'(e_tgt) > EFFW'(MAX_NODES)) || (e_tgt == r_root))
                begin
                    n_state = S_B_TOP;
                end else begin
                    n_t        = e_tgt;
                    node_raddr = AW'(e_tgt);
                    n_state    = S_B_CHK;
                end
            end
            S_B_CHK: begin
                // a parent already set means the node was visited
                if (node_rdata[NW-1:0] != '0) begin
                    n_state = S_B_TOP;
                end else begin
                    n_nrow          = '0;
                    n_nrow[NW-1:0]  = r_top_node;
                    node_raddr      = AW'(r_top_node);
                    n_lvl           = LCW'(1);
                    n_state         = S_B_VL;
                end
            end
            S_B_VL: begin
                // node_rdata is the row of ancestor level r_lvl-1 of the new node
                if (r_lvl == LCW'(1)) begin
                    n_nrow[LEVELS * NW +: DW] = node_rdata[LEVELS * NW +: DW] + DW'(1);
                end
                if (r_lvl < LCW'(LEVELS)) begin
                    n_nrow[r_lvl * NW +: NW] = node_rdata[(r_lvl - LCW'(1)) * NW +: NW];
                    node_raddr = AW'(node_rdata[(r_lvl - LCW'(1)) * NW +: NW]);
                    n_lvl      = r_lvl + LCW'(1);
                end else begin
                    n_state = S_B_VWR;
                end
            end
            S_B_VWR: begin
                node_we    = 1'b1;
                node_waddr = AW'(r_t);
                node_wdata = r_nrow;
                stk_we     = 1'b1;
                stk_waddr  = SW'(r_sp - (SW + 1)'(1));
                stk_wdata  = {r_top_node, r_top_cur};
                adj_raddr  = AW'(r_t);
                n_state    = S_B_PUSH;
            end
            S_B_PUSH: begin
                n_top_node = r_t;
                n_top_cur  = adj_rdata;
                n_sp       = r_sp + (SW + 1)'(1);
                n_state    = S_B_TOP;
            end
            S_Q_A: begin
                n_urow     = node_rdata;
                node_raddr = AW'(r_b);
                n_state    = S_Q_B;
            end
            S_Q_B: begin
                // put the shallower node in u
                if (r_urow[LEVELS * NW +: DW] > node_rdata[LEVELS * NW +: DW]) begin
                    n_u    = r_b;
                    n_urow = node_rdata;
                    n_v    = r_a;
                    n_vrow = r_urow;
                    n_dif  = r_urow[LEVELS * NW +: DW] - node_rdata[LEVELS * NW +: DW];
                end else begin
                    n_u    = r_a;
                    n_v    = r_b;
                    n_vrow = node_rdata;
                    n_dif  = node_rdata[LEVELS * NW +: DW] - r_urow[LEVELS * NW +: DW];
                end
                n_lvl   = LCW'(LEVELS - 1);
                n_state = S_Q_LIFT;
            end
            S_Q_LIFT: begin
                if (dbit) begin
                    n_v        = fv;
                    node_raddr = AW'(fv);
                    n_state    = S_Q_LIFTW;
                end else if (r_lvl == '0) begin
                    n_state = S_Q_EQ;
                end else begin
                    n_lvl = r_lvl - LCW'(1);
                end
            end
            S_Q_LIFTW: begin
                n_vrow = node_rdata;
                if (r_lvl == '0) begin
                    n_state = S_Q_EQ;
                end else begin
                    n_lvl   = r_lvl - LCW'(1);
                    n_state = S_Q_LIFT;
                end
            end
            S_Q_EQ: begin
                if (r_u == r_v) begin
                    n_res   = r_u;
                    n_state = S_FIN;
                end else begin
                    n_lvl   = LCW'(LEVELS - 1);
                    n_state = S_Q_CMP;
                end
            end
            S_Q_CMP: begin
                if (fu != fv) begin
                    n_u        = fu;
                    n_v        = fv;
                    node_raddr = AW'(fu);
                    n_state    = S_Q_CU;
                end else if (r_lvl == '0) begin
                    n_res   = r_urow[NW-1:0];
                    n_state = S_FIN;
                end else begin
                    n_lvl = r_lvl - LCW'(1);
                end
            end
            S_Q_CU: begin
                n_urow     = node_rdata;
                node_raddr = AW'(r_v);
                n_state    = S_Q_CV;
            end
            S_Q_CV: begin
                n_vrow = node_rdata;
                if (r_lvl == '0) begin
                    n_res   = r_urow[NW-1:0];
                    n_state = S_FIN;
                end else begin
                    n_lvl   = r_lvl - LCW'(1);
                    n_state = S_Q_CMP;
                end
            end
            S_FIN: begin
                // hold the result until the output register is free
                if (!r_ov || !i_out_stall) begin
                    n_ov    = 1'b1;
                    n_ores  = r_res;
                    n_ostat = r_stat;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr        <= '0;
            r_clr_adj    <= 1'b1;
            r_node_count <= NW'(1);
            r_root       <= NW'(1);
            r_fill       <= '0;
            r_built      <= 1'b0;
            r_sp         <= '0;
            r_ov         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_clr_adj    <= n_clr_adj;
            r_node_count <= n_node_count;
            r_root       <= n_root;
            r_fill       <= n_fill;
            r_built      <= n_built;
            r_sp         <= n_sp;
            r_ov         <= n_ov;
        end
        r_req      <= n_req;
        r_a        <= n_a;
        r_b        <= n_b;
        r_top_node <= n_top_node;
        r_top_cur  <= n_top_cur;
        r_t        <= n_t;
        r_nrow     <= n_nrow;
        r_lvl      <= n_lvl;
        r_u        <= n_u;
        r_v        <= n_v;
        r_urow     <= n_urow;
        r_vrow     <= n_vrow;
        r_dif      <= n_dif;
        r_res      <= n_res;
        r_stat     <= n_stat;
        r_ores     <= n_ores;
        r_ostat    <= n_ostat;
    end

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= (SW + 1)'(MAX_NODES))
        else $error("walk stack pointer beyond node capacity");

    a_fill_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill[0] == 1'b0) && ((HW + 1)'(r_fill) <= (HW + 1)'(EDGE_CAP)))
        else $error("edge fill odd or past capacity");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_ostat != ST_OK)) |-> (r_ores == '0))
        else $error("error item carries a nonzero result");

    a_add_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AE_B) |=> !r_built)
        else $error("stored edge left the built mark set");

    a_walk_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_B_TOP) && (r_sp == '0)) |=> (r_built && (r_state == S_FIN)))
        else $error("finished walk did not mark tables built");

endmodule
`default_nettype wire

// File: rtl/tlbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tlbl_ram #(
    parameter  int unsigned WIDTH = 8,
    parameter  int unsigned DEPTH = 16,
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: test/tree_lca_binary_lifting_test.sv
// Self-checking testbench for the tree LCA binary-lifting block.
`default_nettype none
module tree_lca_binary_lifting_test;
    import tlbl_pkg::*;

    localparam int unsigned NODES     = 1024;
    localparam int unsigned LVL       = 10;
    localparam int unsigned EDGE_SLOTS = 2 * (NODES - 1);
    localparam logic [1:0]  REQ_SPARE = 2'd3;
    localparam int          LIMIT     = 2_000_000;

    typedef struct {
        logic [NODE_W-1:0] node;
        logic [1:0]        st;
    } answer_t;

    // Answer predictor: keeps a private copy of the edge lists, depth and ancestor
    // tables, and queues the answer each accepted item must produce.
    class lca_scoreboard;
        int unsigned count_reg, root_reg;
        int unsigned head [0:NODES];
        int unsigned tgt [0:EDGE_SLOTS-1];
        int unsigned nxt [0:EDGE_SLOTS-1];
        int unsigned fill;
        int unsigned dep [0:NODES];
        int unsigned anc [0:NODES][0:LVL-1];
        int unsigned stk_node [0:NODES-1];
        int unsigned stk_cur [0:NODES-1];
        bit built;
        answer_t due [$];
        int errors;
        int taken;

        function new();
            count_reg = 1;
            root_reg = 1;
            fill = 0;
            built = 0;
            errors = 0;
            taken = 0;
            foreach (head[i]) head[i] = 0;
            foreach (dep[i]) dep[i] = 0;
            foreach (anc[i, j]) anc[i][j] = 0;
        endfunction

        function void set_reg(logic idx, logic [NODE_W-1:0] val);
            if (idx == CFG_NODE_COUNT) count_reg = val;
            else root_reg = val;
        endfunction

        function bit id_ok(int unsigned x);
            int unsigned lim;
            lim = (count_reg > NODES) ? NODES : count_reg;
            return x >= 1 && x <= lim;
        endfunction

        function void mark(int unsigned n, int unsigned par, int unsigned d);
            dep[n] = d;
            anc[n][0] = par;
            for (int i = 1; i < LVL; i++) anc[n][i] = anc[anc[n][i-1]][i-1];
        endfunction

        // Depth-first walk with an explicit stack, newest neighbor first.
        function void grow(int unsigned root);
            int unsigned sp, cur, e, t;
            foreach (dep[i]) dep[i] = 0;
            foreach (anc[i, j]) anc[i][j] = 0;
            mark(root, 0, 0);
            stk_node[0] = root;
            stk_cur[0] = head[root];
            sp = 1;
            while (sp > 0) begin
                cur = stk_cur[sp-1];
                if (cur == 0) begin
                    sp--;
                    continue;
                end
                e = cur - 1;
                if (e >= EDGE_SLOTS) begin
                    sp--;
                    continue;
                end
                stk_cur[sp-1] = nxt[e];
                t = tgt[e];
                if (t == 0 || t > NODES) continue;
                if (t == root || anc[t][0] != 0) continue;
                if (sp >= NODES) continue;
                mark(t, stk_node[sp-1], dep[stk_node[sp-1]] + 1);
                stk_node[sp] = t;
                stk_cur[sp] = head[t];
                sp++;
            end
        endfunction

        function int unsigned meet(int unsigned u, int unsigned v);
            int unsigned t, dif;
            if (dep[u] > dep[v]) begin
                t = u;
                u = v;
                v = t;
            end
            dif = dep[v] - dep[u];
            for (int i = LVL - 1; i >= 0; i--)
                if ((dif >> i) & 1) v = anc[v][i];
            if (u == v) return u;
            for (int i = LVL - 1; i >= 0; i--)
                if (anc[u][i] != anc[v][i]) begin
                    u = anc[u][i];
                    v = anc[v][i];
                end
            return anc[u][0];
        endfunction

        function void note_request(logic [1:0] req, logic [NODE_W-1:0] a,
                                   logic [NODE_W-1:0] b);
            answer_t r;
            r.node = '0;
            r.st = ST_OK;
            taken++;
            if (req == REQ_ADD) begin
                if (!id_ok(a) || !id_ok(b)) r.st = ST_RANGE;
                else if (fill + 2 > EDGE_SLOTS) r.st = ST_FULL;
                else begin
                    tgt[fill] = b;
                    nxt[fill] = head[a];
                    head[a] = fill + 1;
                    fill++;
                    tgt[fill] = a;
                    nxt[fill] = head[b];
                    head[b] = fill + 1;
                    fill++;
                    built = 0;
                end
            end else if (req == REQ_BUILD) begin
                if (!id_ok(root_reg)) r.st = ST_RANGE;
                else begin
                    grow(root_reg);
                    built = 1;
                end
            end else if (req == REQ_QUERY) begin
                if (!id_ok(a) || !id_ok(b)) r.st = ST_RANGE;
                else if (!built) r.st = ST_NOTBUILT;
                else r.node = NODE_W'(meet(a, b));
            end
            due.insert(due.size(), r);
        endfunction

        function void check_answer(logic [NODE_W-1:0] node, logic [1:0] st);
            answer_t w;
            if (due.size() == 0) begin
                $display("%0t: result with nothing pending: node %0d status %0d",
                         $time, node, st);
                errors++;
                return;
            end
            w = due.pop_front();
            if (node !== w.node) begin
                $display("%0t: result_node expected %0d actual %0d", $time, w.node, node);
                errors++;
            end
            if (st !== w.st) begin
                $display("%0t: status expected %0d actual %0d", $time, w.st, st);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_req_type = '0;
    logic [NODE_W-1:0] i_node_a = '0;
    logic [NODE_W-1:0] i_node_b = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [NODE_W-1:0] o_result_node;
    logic [1:0]        o_status;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index = 1'b0;
    logic [NODE_W-1:0] i_cfg_data = '0;

    lca_scoreboard sb = new();
    bit calm = 0;      // last part of the run: no idling on either side
    int cycles = 0;

    tree_lca_binary_lifting dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one item; return at the edge where it is taken.
    task automatic send_req(logic [1:0] req, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
        int gap;
        gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_node_a <= a;
        i_node_b <= b;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        sb.note_request(req, a, b);
    endtask

    // Drain every pending answer, then write a register while the block is idle.
    task automatic write_reg(logic idx, logic [NODE_W-1:0] val);
        i_in_valid <= 1'b0;
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [NODE_W-1:0] pick(int unsigned lo, int unsigned hi);
        return NODE_W'($urandom_range(lo, hi));
    endfunction

    function automatic logic [1:0] any_req();
        return 2'($urandom_range(0, 3));
    endfunction

    function automatic logic [NODE_W-1:0] any_id();
        return pick(0, 2047);
    endfunction

    // Receiver: check answers, stall in bursts, and hold off once for a long stretch.
    initial begin
        int burst;
        int hold;
        bit held;
        bit nxt;
        burst = 0;
        hold = 0;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) sb.check_answer(o_result_node, o_status);
            if (!held && sb.taken >= 50) begin
                held = 1;
                hold = 400;
            end
            nxt = 1'b0;
            if (hold > 0) begin
                hold--;
                nxt = 1'b1;
            end else if (calm) begin
                burst = 0;
            end else if (burst > 0) begin
                burst--;
                nxt = 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 17) - 1;
                nxt = 1'b1;
            end
            i_out_stall <= nxt;
        end
    end

    initial begin
        int m, n, lim;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: fresh state, range and not-built paths, spare type, extremes.
        send_req(REQ_QUERY, 1, 1);
        send_req(REQ_QUERY, 0, 1);
        send_req(REQ_QUERY, 2047, 2047);
        send_req(REQ_SPARE, 2047, 2047);
        send_req(REQ_ADD, 1, 2);
        send_req(REQ_BUILD, 0, 0);
        send_req(REQ_QUERY, 1, 1);
        write_reg(CFG_NODE_COUNT, 0);
        send_req(REQ_ADD, 1, 1);
        send_req(REQ_BUILD, 0, 0);
        send_req(REQ_QUERY, 1, 1);
        write_reg(CFG_NODE_COUNT, 2047);
        write_reg(CFG_ROOT_NODE, 1024);
        send_req(REQ_ADD, 1024, 1);
        send_req(REQ_ADD, 1, 1);
        send_req(REQ_ADD, 1025, 3);
        send_req(REQ_BUILD, 0, 0);
        send_req(REQ_QUERY, 1, 1024);
        send_req(REQ_QUERY, 5, 6);
        send_req(REQ_QUERY, 5, 1);
        write_reg(CFG_ROOT_NODE, 0);
        send_req(REQ_BUILD, 0, 0);
        send_req(REQ_QUERY, 1024, 1024);
        send_req(REQ_ADD, 3, 4);
        send_req(REQ_QUERY, 3, 4);

        // Deep chain so that the lifting walks many levels.
        write_reg(CFG_NODE_COUNT, 1024);
        write_reg(CFG_ROOT_NODE, 10);
        for (int k = 11; k <= 310; k++) send_req(REQ_ADD, NODE_W'(k - 1), NODE_W'(k));
        send_req(REQ_BUILD, 0, 0);
        for (int k = 0; k < 20; k++)
            send_req(REQ_QUERY, pick(1, 320), pick(1, 320));

        // Random phases: small trees with random shape plus noise.
        while (sb.taken < 500) begin
            case ($urandom_range(0, 19))
                0: n = 0;
                1: n = 1;
                2: n = 1024;
                3: n = 2047;
                default: n = $urandom_range(2, 24);
            endcase
            write_reg(CFG_NODE_COUNT, NODE_W'(n));
            lim = (n > 1024) ? 1024 : n;
            m = (lim > 16) ? $urandom_range(2, 16) : lim;
            if ($urandom_range(0, 6) == 0 || lim == 0) write_reg(CFG_ROOT_NODE, any_id());
            else write_reg(CFG_ROOT_NODE, pick(1, (m > 0) ? m : 1));
            for (int k = 2; k <= m; k++) begin
                if ($urandom_range(0, 6) == 0)
                    send_req(any_req(), any_id(), any_id());
                if ($urandom_range(0, 1))
                    send_req(REQ_ADD, NODE_W'(k), pick(1, k - 1));
                else
                    send_req(REQ_ADD, pick(1, k - 1), NODE_W'(k));
            end
            if ($urandom_range(0, 3) == 0) send_req(REQ_QUERY, 1, 1);
            send_req(REQ_BUILD, any_id(), any_id());
            repeat ($urandom_range(5, 15)) begin
                case ($urandom_range(0, 9))
                    0: send_req(any_req(), any_id(), any_id());
                    1: send_req(REQ_QUERY, pick(0, lim + 1), pick(0, lim + 1));
                    default: send_req(REQ_QUERY, pick(1, (m > 0) ? m : 1),
                                      pick(1, (m > 0) ? m : 1));
                endcase
            end
        end

        // Last part: no idling; a dense graph with cycles and repeated edges.
        calm = 1;
        write_reg(CFG_NODE_COUNT, 8);
        write_reg(CFG_ROOT_NODE, 1);
        repeat (40) send_req(REQ_ADD, pick(1, 8), pick(1, 8));
        send_req(REQ_BUILD, 0, 0);
        repeat (20) send_req(REQ_QUERY, pick(1, 8), pick(1, 8));
        i_in_valid <= 1'b0;

        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire
